// File: src/css_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package css_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int VALUE_W       = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        value_t value;
        logic   is_last;
    } in_item_t;

    typedef struct packed {
        value_t sorted_value;
        logic   last_out;
    } out_item_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;
        logic emit;
        logic sort;
        logic odd_phase;
    } css_ctrl_t;

endpackage

`default_nettype wire

// File: src/cocktail_shaker_sorter.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorts a list of signed 32-bit values into ascending order.
// Input: a transfer takes place on a clock edge with start high and busy low.
// Each transfer carries one value; is_last closes the list. Values beyond
// DEPTH are dropped, but a dropped item with is_last still closes the list.
// Values are held in a row of DEPTH cells that shift in one value per transfer.
// After the closing transfer the row runs odd-even compare-exchange phases,
// one per cycle, n phases for n stored values; busy is high meanwhile.
// The sorted values then shift out of cell 0, one per cycle, each marked by
// strobe, which stays high through the output; last_out is set on the final one.
// The next list is accepted in the cycle after the last output. The receiver
// cannot stall the output.
// Reset empties the row and returns the block to idle, ready for a new list.
module cocktail_shaker_sorter
    import css_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_item_t item,
    output logic          busy,
    output logic          strobe,
    output out_item_t     result
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SORT = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  phase_reg;
    logic [CW-1:0]  phase_next;
    logic           accept;
    logic           room;
    css_ctrl_t      ctrl;

    value_t         cell_val [DEPTH];
    logic           cell_occ [DEPTH];

    assign accept = start && (state_reg == ST_IDLE);
    assign room   = (count_reg != CW'(DEPTH));

    always_comb
    begin
        ctrl.load      = accept && room;
        ctrl.emit      = (state_reg == ST_EMIT);
        ctrl.sort      = (state_reg == ST_SORT);
        ctrl.odd_phase = phase_reg[0];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (item.is_last)
                    begin
                        state_next = ST_SORT;
                        phase_next = '0;
                    end
                end
            end
            ST_SORT:
            begin
                phase_next = phase_reg + CW'(1);
                if (phase_reg == count_reg - CW'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                count_next = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            value_t lv;
            logic   lo;
            value_t rv;
            logic   ro;

            if (i == 0)
            begin : g_first
                // The input only counts as a neighbor while a value is being
                // loaded, so cell 0 never pairs with it during sorting.
                assign lv = item.value;
                assign lo = ctrl.load;
            end
            else
            begin : g_mid_l
                assign lv = cell_val[i-1];
                assign lo = cell_occ[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign rv = '0;
                assign ro = 1'b0;
            end
            else
            begin : g_mid_r
                assign rv = cell_val[i+1];
                assign ro = cell_occ[i+1];
            end

            css_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .odd_pos   (1'(i % 2)),
                .left_val  (lv),
                .left_occ  (lo),
                .right_val (rv),
                .right_occ (ro),
                .val       (cell_val[i]),
                .occ       (cell_occ[i])
            );
        end
    endgenerate

    assign busy                = (state_reg != ST_IDLE);
    assign strobe              = (state_reg == ST_EMIT);
    assign result.sorted_value = cell_val[0];
    assign result.last_out     = (count_reg == CW'(1));

endmodule

`default_nettype wire

// File: src/css_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module css_cell
    import css_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire css_ctrl_t ctrl,
    input  wire logic      odd_pos,
    input  wire value_t    left_val,
    input  wire logic      left_occ,
    input  wire value_t    right_val,
    input  wire logic      right_occ,
    output value_t         val,
    output logic           occ
);

    value_t val_reg;
    value_t val_next;
    logic   occ_reg;
    logic   occ_next;

    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        if (ctrl.load)
        begin
            val_next = left_val;
            occ_next = left_occ;
        end
        else if (ctrl.emit)
        begin
            val_next = right_val;
            occ_next = right_occ;
        end
        else if (ctrl.sort)
        begin
            // A cell whose position parity matches the phase is the lower
            // end of its pair and keeps the minimum; the other keeps the maximum.
            if (odd_pos == ctrl.odd_phase)
            begin
                if (occ_reg && right_occ && (val_reg > right_val))
                begin
                    val_next = right_val;
                end
            end
            else
            begin
                if (occ_reg && left_occ && (left_val > val_reg))
                begin
                    val_next = left_val;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign occ = occ_reg;

endmodule

`default_nettype wire
